// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define DQ_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// When the trigger holds, the consequence must hold in the next cycle.
`define DQ_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);
`else
`define DQ_ASSERT(lbl, cond, msg)
`define DQ_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

// ----- rtl/core/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Request codes, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;

   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ_POS   = 3'd4;

   typedef struct packed {
      logic load_req;   // capture the request fields
      logic exec;       // check the request, update pointers, access the store
      logic load_rsp;   // capture the result into the output register
   } dq_cmd_type;

endpackage

// ----- rtl/core/dq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one request at a time: accept, execute, capture, deliver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output dq_pkg::dq_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_LOAD;
         end
         // Read data from the store is valid in this cycle.
         ST_LOAD: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   `DQ_ASSERT(a_no_overlap, !(req_tready && rsp_tvalid), "request taken while result pending")
   `DQ_ASSERT_NEXT(a_load_exec, cmd.load_req, cmd.exec, "accepted request not executed")
   `DQ_ASSERT_NEXT(a_rsp_valid, cmd.load_rsp, rsp_tvalid, "captured result not presented")

endmodule

// ----- rtl/core/dq_dpath.sv -----
// ----------------------------------------------------------------------------
// Deque datapath
// Request registers, ring pointers, element store and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_dpath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dq_pkg::dq_cmd_type                cmd,
   input  logic [dq_pkg::MODE_W-1:0]         mode,
   input  logic signed [dq_pkg::VALUE_W-1:0] value_in,
   input  logic [dq_pkg::POS_W-1:0]          position,
   output logic signed [dq_pkg::VALUE_W-1:0] value_out,
   output logic                              error,
   output logic [dq_pkg::COUNT_W-1:0]        count
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;
   localparam logic [PW:0]   SUM_DEPTH = (PW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL      = CW'(DEPTH);

   // Request fields held for the execute cycle.
   logic [dq_pkg::MODE_W-1:0]         mode_ff;
   logic signed [dq_pkg::VALUE_W-1:0] value_ff;
   logic [dq_pkg::POS_W-1:0]          pos_ff;

   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] held_ff, held_in;
   logic          from_ram_ff;

   logic signed [dq_pkg::VALUE_W-1:0] value_out_ff;
   logic                              error_ff;
   logic [dq_pkg::COUNT_W-1:0]        count_ff;

   logic                  exec_err;
   logic                  wr_en;
   logic                  rd_en;
   logic [PW-1:0]         addr;
   logic [PW-1:0]         front_dec;
   logic                  full;
   logic                  empty;
   logic                  pos_ok;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;

   // Base plus offset, both below DEPTH, folded back into the ring.
   function automatic logic [PW-1:0] wrap_slot(input logic [PW-1:0] base,
                                                input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= SUM_DEPTH) begin
         sum = sum - SUM_DEPTH;
      end
      return sum[PW-1:0];
   endfunction

   assign full      = (held_ff == FULL);
   assign empty     = (held_ff == '0);
   assign pos_ok    = (pos_ff != '0) && (CMPW'(pos_ff) <= CMPW'(held_ff));
   assign front_dec = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - PW'(1);
   assign wr_data   = DATA_WIDTH'(value_ff);

   always_comb begin
      exec_err = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      addr     = front_ff;
      front_in = front_ff;
      held_in  = held_ff;
      unique case (mode_ff)
         dq_pkg::MODE_PUSH_BACK: begin
            exec_err = full;
            addr     = wrap_slot(front_ff, PW'(held_ff));
            wr_en    = !full;
            if (!full) begin
               held_in = held_ff + CW'(1);
            end
         end
         dq_pkg::MODE_PUSH_FRONT: begin
            exec_err = full;
            addr     = front_dec;
            wr_en    = !full;
            if (!full) begin
               front_in = front_dec;
               held_in  = held_ff + CW'(1);
            end
         end
         dq_pkg::MODE_POP_BACK: begin
            exec_err = empty;
            addr     = wrap_slot(front_ff, PW'(held_ff - CW'(1)));
            rd_en    = !empty;
            if (!empty) begin
               held_in = held_ff - CW'(1);
            end
         end
         dq_pkg::MODE_POP_FRONT: begin
            exec_err = empty;
            addr     = front_ff;
            rd_en    = !empty;
            if (!empty) begin
               front_in = wrap_slot(front_ff, PW'(1));
               held_in  = held_ff - CW'(1);
            end
         end
         dq_pkg::MODE_READ_POS: begin
            exec_err = !pos_ok;
            addr     = wrap_slot(front_ff, PW'(pos_ff - dq_pkg::POS_W'(1)));
            rd_en    = pos_ok;
         end
         default: begin
            exec_err = 1'b1;
         end
      endcase
   end

   dq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (cmd.exec && rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         held_ff  <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= mode;
         value_ff <= value_in;
         pos_ff   <= position;
      end
      if (cmd.exec) begin
         from_ram_ff <= rd_en;
         error_ff    <= exec_err;
      end
      if (cmd.load_rsp) begin
         value_out_ff <= from_ram_ff ? dq_pkg::VALUE_W'(rd_data) : '0;
         count_ff     <= dq_pkg::COUNT_W'(held_ff);
      end
   end

   assign value_out = value_out_ff;
   assign error     = error_ff;
   assign count     = count_ff;

   `DQ_ASSERT(a_held_bound, held_ff <= FULL, "element count beyond depth")
   `DQ_ASSERT(a_front_bound, PW'(front_ff) <= PW'(DEPTH - 1), "front pointer outside ring")
   `DQ_ASSERT_NEXT(a_err_keeps, cmd.exec && exec_err,
      $stable(held_ff) && $stable(front_ff), "rejected request changed the state")

endmodule

// ----- rtl/core/double_ended_queue_top.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque on a ring buffer: push and pop at either end, read by position.
//
//   Group   Dir   tdata (low bit first)                 tuser
//   req_    in    value_in[31:0], position[38:32]       mode[2:0]
//   rsp_    out   value_out[31:0], count[38:32]         error
//
// The result is offered after the request transfer, once the execute state (one
// store write or read) and the load state (read data return with result capture)
// have passed, and it transfers when rsp_tready is high; the next request is
// taken only after the result transfer, so one item is handled at a time.
// The store has one registered read port, which sets the execute/return pair.
// Only one request is in flight; req_tready stays low until the result transfer.
// Reset clears the pointers and the count; the store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value_in[31:0], position[38:32], zero pad
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value_out[31:0], count[38:32], zero pad
   output logic [0:0]  rsp_tuser    // error[0]
);

   dq_pkg::dq_cmd_type cmd;

   logic signed [dq_pkg::VALUE_W-1:0] value_in;
   logic [dq_pkg::POS_W-1:0]          position;
   logic signed [dq_pkg::VALUE_W-1:0] value_out;
   logic                              error;
   logic [dq_pkg::COUNT_W-1:0]        count;

   assign value_in = req_tdata[31:0];
   assign position = req_tdata[38:32];

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .mode      (req_tuser),
      .value_in  (value_in),
      .position  (position),
      .value_out (value_out),
      .error     (error),
      .count     (count)
   );

   assign rsp_tdata = {1'b0, count, value_out};
   assign rsp_tuser = error;

endmodule

// ----- tb/double_ended_queue_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, position-read and invalid-code requests with random pacing on both
// streams, predicts every result with a private ring-buffer copy of the deque
// and compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

   localparam int DEQUE_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1900;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 8;
   // Codes the block must reject as invalid requests.
   localparam logic [dq_pkg::MODE_W-1:0] MODE_FIRST_BAD = 3'd5;
   localparam logic [dq_pkg::MODE_W-1:0] MODE_LAST_BAD  = 3'd7;

   typedef struct packed {
      logic [dq_pkg::VALUE_W-1:0] value;
      logic                       rejected;
      logic [dq_pkg::COUNT_W-1:0] count;
   } deque_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // value_in[31:0], position[38:32], zero pad
   logic [2:0]  req_tuser = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // value_out[31:0], count[38:32], zero pad
   logic [0:0]  rsp_tuser;        // error[0]

   // Private copy of the deque, updated as each request transfer is accepted.
   logic [dq_pkg::VALUE_W-1:0] ring_store [DEQUE_DEPTH];
   logic [5:0]                 front_slot = '0;
   logic [dq_pkg::COUNT_W-1:0] held_count = '0;

   deque_result_type pending_results [$];
   int mismatch_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int hold_requests = 0;

   double_ended_queue_top #(
      .DEPTH(DEQUE_DEPTH),
      .DATA_WIDTH(dq_pkg::VALUE_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s: got %08h, expected %08h", what, got, want);
      mismatch_count++;
   endtask

   function automatic deque_result_type deque_apply(
         input logic [dq_pkg::MODE_W-1:0] mode,
         input logic [dq_pkg::VALUE_W-1:0] value,
         input logic [dq_pkg::POS_W-1:0] position);
      deque_result_type res;
      logic [5:0] slot;
      res = '0;
      case (mode)
         dq_pkg::MODE_PUSH_BACK: begin
            if (held_count == DEQUE_DEPTH) begin
               res.rejected = 1'b1;
            end else begin
               slot = front_slot + held_count[5:0];
               ring_store[slot] = value;
               held_count++;
            end
         end
         dq_pkg::MODE_PUSH_FRONT: begin
            if (held_count == DEQUE_DEPTH) begin
               res.rejected = 1'b1;
            end else begin
               front_slot = front_slot - 6'd1;
               ring_store[front_slot] = value;
               held_count++;
            end
         end
         dq_pkg::MODE_POP_BACK: begin
            if (held_count == 0) begin
               res.rejected = 1'b1;
            end else begin
               slot = front_slot + 6'(held_count - 7'd1);
               res.value = ring_store[slot];
               held_count--;
            end
         end
         dq_pkg::MODE_POP_FRONT: begin
            if (held_count == 0) begin
               res.rejected = 1'b1;
            end else begin
               res.value = ring_store[front_slot];
               front_slot = front_slot + 6'd1;
               held_count--;
            end
         end
         dq_pkg::MODE_READ_POS: begin
            if (position == 0 || position > held_count) begin
               res.rejected = 1'b1;
            end else begin
               slot = front_slot + 6'(position - 7'd1);
               res.value = ring_store[slot];
            end
         end
         default: res.rejected = 1'b1;
      endcase
      res.count = held_count;
      return res;
   endfunction

   // Offers one request and waits for its transfer. Within a burst the valid
   // stays high so the next call follows on; after a burst it drops and pauses.
   task automatic send_request(input logic [dq_pkg::MODE_W-1:0] mode,
                               input logic [dq_pkg::VALUE_W-1:0] value,
                               input logic [dq_pkg::POS_W-1:0] position);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, position, value};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(deque_apply(mode, value, position));
      items_sent++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   // Stops offering and waits until every predicted result has transferred or the drain limit is reached.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (pending_results.size() != 0) begin
         report_mismatch("result never arrived", '0, pending_results[0].value);
         void'(pending_results.pop_front());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_request(input int fill_target);
      int unsigned roll;
      int unsigned push_pct;
      logic [dq_pkg::MODE_W-1:0] mode;
      logic [dq_pkg::POS_W-1:0] position;
      roll = $urandom_range(99);
      position = dq_pkg::POS_W'($urandom);
      if (roll < 3) begin
         mode = dq_pkg::MODE_W'($urandom_range(MODE_FIRST_BAD, MODE_LAST_BAD));
      end else if (roll < 20) begin
         mode = dq_pkg::MODE_READ_POS;
         case ($urandom_range(9))
            0: position = '0;
            1: position = held_count + 7'd1;
            2: ;
            default: begin
               if (held_count != 0)
                  position = dq_pkg::POS_W'($urandom_range(1, held_count));
            end
         endcase
      end else begin
         if (held_count < fill_target) push_pct = 80;
         else if (held_count > fill_target) push_pct = 20;
         else push_pct = 50;
         if ($urandom_range(99) < push_pct)
            mode = $urandom_range(1) ? dq_pkg::MODE_PUSH_FRONT : dq_pkg::MODE_PUSH_BACK;
         else
            mode = $urandom_range(1) ? dq_pkg::MODE_POP_FRONT : dq_pkg::MODE_POP_BACK;
      end
      send_request(mode, $urandom, position);
   endtask

   task automatic test_empty_requests();
      send_request(dq_pkg::MODE_POP_BACK, 32'h0000_0000, 7'd0);
      send_request(dq_pkg::MODE_POP_FRONT, 32'hFFFF_FFFF, 7'h7F);
      send_request(dq_pkg::MODE_READ_POS, 32'h1234_5678, 7'd1);
      send_request(dq_pkg::MODE_READ_POS, 32'h0, 7'd0);
      for (int m = MODE_FIRST_BAD; m <= MODE_LAST_BAD; m++)
         send_request(dq_pkg::MODE_W'(m), $urandom, dq_pkg::POS_W'($urandom));
      drain_results();
   endtask

   task automatic test_ends_and_positions();
      send_request(dq_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 7'd0);
      send_request(dq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 7'h40);
      send_request(dq_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF, 7'h7F);
      send_request(dq_pkg::MODE_PUSH_FRONT, 32'h0000_0000, 7'd3);
      send_request(dq_pkg::MODE_READ_POS, 32'h0, 7'd0);
      send_request(dq_pkg::MODE_READ_POS, 32'h0, 7'd1);
      send_request(dq_pkg::MODE_READ_POS, 32'h0, 7'd4);
      send_request(dq_pkg::MODE_READ_POS, 32'h0, 7'd5);
      send_request(dq_pkg::MODE_POP_FRONT, 32'h0, 7'd0);
      send_request(dq_pkg::MODE_POP_BACK, 32'h0, 7'd0);
      send_request(dq_pkg::MODE_POP_FRONT, 32'h0, 7'd0);
      // Taking the last element must leave the deque empty.
      send_request(dq_pkg::MODE_POP_BACK, 32'h0, 7'd0);
      send_request(dq_pkg::MODE_POP_BACK, 32'h0, 7'd0);
      drain_results();
   endtask

   task automatic test_output_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (16) send_random_request(DEQUE_DEPTH / 2);
      drain_results();
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int fill_target;
      int seg_len;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(3))
            0: begin fill_target = 0; seg_len = $urandom_range(20, 100); end
            1: begin fill_target = DEQUE_DEPTH; seg_len = $urandom_range(100, 180); end
            default: begin
               fill_target = $urandom_range(0, DEQUE_DEPTH);
               seg_len = $urandom_range(20, 100);
            end
         endcase
         repeat (seg_len) send_random_request(fill_target);
         if ($urandom_range(3) == 0) drain_results();
      end
      drain_results();
   endtask

   // Result receiver: a long hold-off on request, otherwise random stalls
   // whose density is redrawn at the end of each random-length pattern.
   initial begin
      int hold_served;
      int hold_left;
      int pattern_left;
      int unsigned stall_pct;
      hold_served = 0;
      hold_left = 0;
      pattern_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(2))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  default: stall_pct = 60;
               endcase
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_tdata[31:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch("value_out", rsp_tdata[31:0], want.value);
            if (rsp_tuser[0] !== want.rejected)
               report_mismatch("error", 32'(rsp_tuser[0]), 32'(want.rejected));
            if (rsp_tdata[38:32] !== want.count)
               report_mismatch("count", 32'(rsp_tdata[38:32]), 32'(want.count));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_requests();
      test_ends_and_positions();
      test_output_backpressure();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
